// ===== sv/fbc_pkg.sv =====
// Shared constants, codes and control/status types of the frustum box cull test.
package fbc_pkg;

    localparam int NUM_PLANES      = 6;
    localparam int FRAC_BITS       = 16;
    localparam int COEFS_PER_PLANE = 4;

    localparam int COEF_W  = 32;
    localparam int EPS_W   = 16;
    localparam int PLANE_W = 3;
    localparam int CIDX_W  = 2;

    // Full-width products and sums: three 64-bit products plus a shifted bias.
    localparam int PROD_W = 2 * COEF_W;
    localparam int SUM_W  = PROD_W + 4;
    localparam int BIAS_W = COEF_W + 2;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(655);

    // Stream packing of the request channel.
    localparam int S_TDATA_W   = 136;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 8;
    localparam int OFS_PLANE   = 0;
    localparam int OFS_CIDX    = OFS_PLANE + PLANE_W;
    localparam int OFS_COEF    = OFS_CIDX + CIDX_W;
    localparam int OFS_VX      = OFS_COEF + COEF_W;
    localparam int OFS_VY      = OFS_VX + COEF_W;
    localparam int OFS_VZ      = OFS_VY + COEF_W;
    localparam int S_USED_W    = OFS_VZ + COEF_W;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_TEST  = 1'b1
    } fbc_func_t;

    typedef enum logic [CIDX_W-1:0] {
        COEF_NX = 2'd0,
        COEF_NY = 2'd1,
        COEF_NZ = 2'd2,
        COEF_D  = 2'd3
    } fbc_coef_t;

    typedef struct packed {
        logic               ld_vertex;
        logic               wr_coef;
        logic               issue;
        logic [PLANE_W-1:0] plane;
        logic               emit;
    } fbc_cmd_t;

    typedef struct packed {
        logic busy;
        logic last;
        logic out_free;
    } fbc_sts_t;

endpackage

// ===== sv/fbc_ctrl.sv =====
// Controller state machine: accepts requests, steps planes, drains and emits.
module fbc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    input  fbc_pkg::fbc_func_t   req_func,
    output logic                 req_ready,
    input  fbc_pkg::fbc_sts_t    sts,
    output fbc_pkg::fbc_cmd_t    cmd
);
    import fbc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_RESULT = 4'b1000
    } fbc_state_t;

    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(NUM_PLANES - 1);

    fbc_state_t         state_reg, state_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
        end else begin
            state_reg <= state_next;
            plane_reg <= plane_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        plane_next = plane_reg;
        cmd        = '0;
        cmd.plane  = plane_reg;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    if (req_func == FUNC_TEST) begin
                        cmd.ld_vertex = 1'b1;
                        plane_next    = '0;
                        state_next    = ST_ISSUE;
                    end else begin
                        cmd.wr_coef = 1'b1;
                    end
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (plane_reg == LAST_PLANE) begin
                    state_next = ST_DRAIN;
                end else begin
                    plane_next = plane_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = sts.last ? ST_RESULT : ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_issue_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        req_ready |-> !cmd.issue && !cmd.emit)
        else $error("plane issued or result emitted while taking requests");

    a_last_plane_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && cmd.plane == LAST_PLANE) |=> state_reg == ST_DRAIN)
        else $error("last plane issued without entering drain");

    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free && !sts.busy)
        else $error("result emitted into a full output register");

endmodule

// ===== sv/fbc_datapath.sv =====
// Datapath: plane table, shared dot-product pipeline, front mask and output register.
module fbc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fbc_pkg::fbc_cmd_t             cmd,
    output fbc_pkg::fbc_sts_t             sts,
    input  logic                          cfg_wr_en,
    input  logic [fbc_pkg::EPS_W-1:0]     cfg_wr_data,
    input  logic [fbc_pkg::PLANE_W-1:0]   plane_index,
    input  logic [fbc_pkg::CIDX_W-1:0]    coef_index,
    input  logic [fbc_pkg::COEF_W-1:0]    coef_value,
    input  logic [fbc_pkg::COEF_W-1:0]    vx,
    input  logic [fbc_pkg::COEF_W-1:0]    vy,
    input  logic [fbc_pkg::COEF_W-1:0]    vz,
    input  logic                          last_vertex,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          inside_res
);
    import fbc_pkg::*;

    // Plane table: one bank per coefficient, indexed by plane.
    logic [COEF_W-1:0]          coef_mem [COEFS_PER_PLANE][NUM_PLANES];
    logic [COEFS_PER_PLANE-1:0] bank_we;
    logic [COEF_W-1:0]          coef_rd_reg [COEFS_PER_PLANE];

    logic [EPS_W-1:0]  eps_reg;
    logic [COEF_W-1:0] vx_reg, vy_reg, vz_reg;
    logic              last_reg;

    // Pipeline valids and plane tags.
    logic               v1_reg, v2_reg, v3_reg;
    logic [PLANE_W-1:0] p1_reg, p2_reg, p3_reg;

    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [BIAS_W-1:0] bias_sum;
    logic signed [SUM_W-1:0]  bias_reg, bias_next;
    logic signed [SUM_W-1:0]  sum_a_reg, sum_b_reg, total;

    logic [NUM_PLANES-1:0] seen_reg, seen_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  inside_reg;
    logic                  out_free;

    always_comb begin
        bank_we = '0;
        if (cmd.wr_coef && (32'(plane_index) < NUM_PLANES)) begin
            case (coef_index)
                COEF_NX: bank_we[COEF_NX] = 1'b1;
                COEF_NY: bank_we[COEF_NY] = 1'b1;
                COEF_NZ: bank_we[COEF_NZ] = 1'b1;
                COEF_D:  bank_we[COEF_D]  = 1'b1;
                default: bank_we = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < COEFS_PER_PLANE; c++) begin
            if (bank_we[c]) begin
                coef_mem[c][plane_index] <= coef_value;
            end
            coef_rd_reg[c] <= coef_mem[c][cmd.plane];
        end
    end

    // Stage 2 products and bias; stage 3 partial sums.
    always_comb begin
        prod_x_next = $signed(coef_rd_reg[COEF_NX]) * $signed(vx_reg);
        prod_y_next = $signed(coef_rd_reg[COEF_NY]) * $signed(vy_reg);
        prod_z_next = $signed(coef_rd_reg[COEF_NZ]) * $signed(vz_reg);
        bias_sum    = BIAS_W'($signed(coef_rd_reg[COEF_D])) +
                      BIAS_W'($signed({1'b0, eps_reg}));
        bias_next   = SUM_W'(bias_sum) <<< FRAC_BITS;
        total       = sum_a_reg + sum_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_vertex) begin
            vx_reg   <= vx;
            vy_reg   <= vy;
            vz_reg   <= vz;
            last_reg <= last_vertex;
        end
        p1_reg     <= cmd.plane;
        p2_reg     <= p1_reg;
        p3_reg     <= p2_reg;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        prod_z_reg <= prod_z_next;
        bias_reg   <= bias_next;
        sum_a_reg  <= SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg);
        sum_b_reg  <= SUM_W'(prod_z_reg) + bias_reg;
        inside_reg <= cmd.emit ? (&seen_reg) : inside_reg;
    end

    always_comb begin
        seen_next = seen_reg;
        if (v3_reg && !total[SUM_W-1]) begin
            seen_next[p3_reg] = 1'b1;
        end
        if (cmd.emit) begin
            seen_next = '0;
        end
    end

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg       <= EPS_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                eps_reg <= cfg_wr_data;
            end
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.busy     = v1_reg || v2_reg || v3_reg;
    assign sts.last     = last_reg;
    assign sts.out_free = out_free;
    assign out_valid    = out_valid_reg;
    assign inside_res   = inside_reg;

    a_idle_pipe_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ld_vertex || cmd.wr_coef) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("request taken while dot-product pipeline busy");

    a_emit_clears_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> out_valid_reg && seen_reg == '0)
        else $error("emit did not load output or clear front mask");

    a_pipe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> $past(v2_reg))
        else $error("pipeline stage valid out of order");

endmodule

// ===== sv/frustum_box_cull_test.sv =====
// Top level of the six-plane frustum cull test: stream ports, controller and datapath.
// Sequencing: a coefficient write request is taken and written while idle; a vertex request
//   holds the one shared dot-product unit while it steps over the six planes, then waits for
//   its three pipeline stages to drain and for the pipeline to be seen empty before another
//   request is taken; the last vertex of a shape then also loads the output register with
//   the result of the shape for m_axis, waiting first until that register is free.
// Reset (aresetn low, synchronous): control, pipeline valids, front mask and output clear;
//   behind_epsilon returns to 655. The plane table is not cleared and must be written first.
module frustum_box_cull_test (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata from bit 0: plane_index[2:0], coef_index[4:3], coef_value[36:5],
    //   vx[68:37], vy[100:69], vz[132:101], zero fill[135:133]
    input  logic [fbc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: func (0 write coefficient, 1 test vertex)
    input  logic [fbc_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // tlast: last_vertex
    input  logic                             s_axis_tlast,
    // Result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata from bit 0: inside_res[0], zero fill[7:1]
    output logic [fbc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // Configuration: behind_epsilon
    input  logic                             cfg_wr_en,
    input  logic [fbc_pkg::EPS_W-1:0]        cfg_wr_data
);
    import fbc_pkg::*;

    fbc_cmd_t  cmd;
    fbc_sts_t  sts;
    fbc_func_t req_func;
    logic      inside_res;

    // Decode the request kind from tuser.
    assign req_func = fbc_func_t'(s_axis_tuser[0]);

    // Sequence each request: writes land at once, vertices step through all planes.
    fbc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_func  (req_func),
        .req_ready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Unpack the request fields straight into the datapath; it latches the vertex on accept.
    fbc_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .plane_index (s_axis_tdata[OFS_PLANE +: PLANE_W]),
        .coef_index  (s_axis_tdata[OFS_CIDX +: CIDX_W]),
        .coef_value  (s_axis_tdata[OFS_COEF +: COEF_W]),
        .vx          (s_axis_tdata[OFS_VX +: COEF_W]),
        .vy          (s_axis_tdata[OFS_VY +: COEF_W]),
        .vz          (s_axis_tdata[OFS_VZ +: COEF_W]),
        .last_vertex (s_axis_tlast),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .inside_res  (inside_res)
    );

    // Pad the single result bit out to a whole byte.
    assign m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, inside_res};

endmodule

// ===== test/fbc_check_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard class: predicts the inside/culled verdict of each shape and checks the block.
package fbc_check_pkg;

    import fbc_pkg::*;

    typedef logic signed [127:0] wide_t;

    class cull_tracker;

        logic [COEF_W-1:0]     coef_mem [NUM_PLANES*COEFS_PER_PLANE];
        logic [NUM_PLANES-1:0] front_seen;
        logic [EPS_W-1:0]      epsilon;
        bit                    inside_expected [$];
        int unsigned           errors;

        function new();
            foreach (coef_mem[i]) coef_mem[i] = '0;
            front_seen = '0;
            epsilon    = EPS_RESET;
            errors     = 0;
        endfunction

        function void set_epsilon(logic [EPS_W-1:0] value);
            epsilon = value;
        endfunction

        // True when the exact signed distance of the vertex to plane p, plus the tolerance, is negative (Q.32).
        function bit plane_behind(int p, logic signed [COEF_W-1:0] x,
                                  logic signed [COEF_W-1:0] y,
                                  logic signed [COEF_W-1:0] z);
            longint signed nx;
            longint signed ny;
            longint signed nz;
            longint signed d;
            longint signed tol;
            wide_t         acc;
            wide_t         term;
            nx  = longint'($signed(coef_mem[p*COEFS_PER_PLANE + COEF_NX]));
            ny  = longint'($signed(coef_mem[p*COEFS_PER_PLANE + COEF_NY]));
            nz  = longint'($signed(coef_mem[p*COEFS_PER_PLANE + COEF_NZ]));
            d   = longint'($signed(coef_mem[p*COEFS_PER_PLANE + COEF_D]));
            tol = longint'({1'b0, epsilon});
            term = nx * longint'(x);
            acc  = term;
            term = ny * longint'(y);
            acc  = acc + term;
            term = nz * longint'(z);
            acc  = acc + term;
            term = d <<< FRAC_BITS;
            acc  = acc + term;
            term = tol <<< FRAC_BITS;
            acc  = acc + term;
            return acc[127];
        endfunction

        function void note_request(fbc_func_t func, logic [PLANE_W-1:0] plane,
                                   fbc_coef_t cidx, logic [COEF_W-1:0] coef,
                                   logic [COEF_W-1:0] vx, logic [COEF_W-1:0] vy,
                                   logic [COEF_W-1:0] vz, bit last);
            logic [NUM_PLANES-1:0] front;
            if (func == FUNC_WRITE) begin
                // writes past the last plane are dropped
                if (plane < NUM_PLANES)
                    coef_mem[plane*COEFS_PER_PLANE + cidx] = coef;
                return;
            end
            front = '0;
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (!plane_behind(p, vx, vy, vz))
                    front[p] = 1'b1;
            end
            front_seen = front_seen | front;
            if (last) begin
                inside_expected.push_back(&front_seen);
                front_seen = '0;
            end
        endfunction

        function void check_inside(bit actual);
            bit want;
            if (inside_expected.size() == 0) begin
                $display("%0t unexpected result: expected none, actual inside_res %0d",
                         $time, actual);
                errors++;
                return;
            end
            want = inside_expected.pop_front();
            if (want != actual) begin
                $display("%0t inside_res mismatch: expected %0d, actual %0d",
                         $time, want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return inside_expected.size();
        endfunction

    endclass

endpackage

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives requests and configuration into the frustum cull block and checks results.
module tb;

    import fbc_pkg::*;
    import fbc_check_pkg::*;

    localparam int ONE          = 32'h0001_0000;   // 1.0 in Q16.16
    localparam int SETTLE       = 40;              // result latency plus a vertex in flight
    localparam int HOLD_CYCLES  = 400;             // long receiver hold-off
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 160;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 cfg_wr_en;
    logic [EPS_W-1:0]     cfg_wr_data;

    cull_tracker      tracker;
    int               src_idle_pct;
    int               sink_stall_pct;
    int               hold_req;
    int               box_h;
    int               requests_sent;
    int unsigned      cycle_count;
    logic [EPS_W-1:0] cur_eps;

    frustum_box_cull_test u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // 12 ns clock, low first so the run opens on a falling edge
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Watchdog: fail and end the run once the total run length reaches LIMIT_CYCLES
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** frustum_box_cull_test: FAILED **");
            $finish;
        end
    end

    // Check every accepted result against the oldest predicted verdict
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            tracker.check_inside(m_axis_tdata[0]);
    end

    // Result side: stall at random, or hold off for a long stretch on request
    initial begin : sink_proc
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Offer one request; idle the bus at random first, then hold it until accepted
    task automatic send_req(fbc_func_t func, logic [PLANE_W-1:0] plane, fbc_coef_t cidx,
                            logic [COEF_W-1:0] coef, logic [COEF_W-1:0] vx,
                            logic [COEF_W-1:0] vy, logic [COEF_W-1:0] vz, bit last);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, vz, vy, vx, coef, cidx, plane};
        s_axis_tuser  <= func;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        tracker.note_request(func, plane, cidx, coef, vx, vy, vz, last);
        requests_sent++;
    endtask

    // Coefficient write; the unused vertex fields and tlast carry noise
    task automatic send_write(int plane, fbc_coef_t cidx, logic [COEF_W-1:0] coef);
        send_req(FUNC_WRITE, PLANE_W'(plane), cidx, coef, $urandom, $urandom, $urandom,
                 1'($urandom_range(1)));
    endtask

    // Vertex test; the unused write fields carry noise
    task automatic send_vertex(logic [COEF_W-1:0] x, logic [COEF_W-1:0] y,
                               logic [COEF_W-1:0] z, bit last);
        send_req(FUNC_TEST, PLANE_W'($urandom_range(7)), fbc_coef_t'($urandom_range(3)),
                 $urandom, x, y, z, last);
    endtask

    task automatic bus_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Load an axis-aligned box of half-size h: planes +x, -x, +y, -y, +z, -z
    task automatic load_box(int h);
        int sgn;
        for (int p = 0; p < NUM_PLANES; p++) begin
            sgn = (p % 2 == 0) ? ONE : -ONE;
            for (int c = 0; c < COEFS_PER_PLANE; c++) begin
                if (c == COEF_D)
                    send_write(p, fbc_coef_t'(c), h);
                else
                    send_write(p, fbc_coef_t'(c), (c == p / 2) ? sgn : 0);
            end
        end
        box_h = h;
    endtask

    // Wait until every predicted result has arrived, then let the pipeline settle
    task automatic drain();
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Epsilon is written only while the block is idle
    task automatic write_epsilon(logic [EPS_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_epsilon(value);
        cur_eps = value;
    endtask

    // One coordinate around a center: mostly near the center, some on the boundary, some wild
    function automatic int pick_coord(int center);
        int r;
        int edge_dist;
        r = $urandom_range(99);
        edge_dist = box_h + int'(cur_eps);
        if (r < 4)
            return $urandom;
        if (r < 14) begin
            if ($urandom_range(1) == 1)
                edge_dist = edge_dist + 1;
            return ($urandom_range(1) == 1) ? edge_dist : -edge_dist;
        end
        return center + int'($urandom_range(box_h)) - box_h / 2;
    endfunction

    // Random coefficient value: extremes now and then, otherwise full range
    function automatic int wild_coef();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed shapes over a sane frustum, with writes mixed in
    task automatic run_phase(int n_items);
        int target;
        int r;
        int nv;
        int cx;
        int cy;
        int cz;
        int span;
        target = requests_sent + n_items;
        while (requests_sent < target) begin
            r = $urandom_range(99);
            if (r < 4) begin
                // noise write, plane index may be out of range
                send_write($urandom_range(7), fbc_coef_t'($urandom_range(3)), wild_coef());
            end else if (r < 8) begin
                // nudge one plane: new intercept or tilted normal component
                if ($urandom_range(1) == 1)
                    send_write($urandom_range(NUM_PLANES - 1), COEF_D,
                               $urandom_range(16 * ONE, ONE / 4));
                else
                    send_write($urandom_range(NUM_PLANES - 1),
                               fbc_coef_t'($urandom_range(COEF_NZ)),
                               int'($urandom_range(2 * ONE)) - ONE);
            end else if (r < 9) begin
                load_box($urandom_range(16 * ONE, ONE / 4));
            end else begin
                nv   = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
                span = 3 * box_h;
                cx   = int'($urandom_range(2 * span)) - span;
                cy   = int'($urandom_range(2 * span)) - span;
                cz   = int'($urandom_range(2 * span)) - span;
                for (int v = 0; v < nv; v++)
                    send_vertex(pick_coord(cx), pick_coord(cy), pick_coord(cz), v == nv - 1);
            end
        end
    endtask

    initial begin : main_proc
        int               h;
        logic [EPS_W-1:0] eps_set [5];
        int               src_set [5];
        int               sink_set [5];

        // Drive every input to a known value from time zero
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 0;
        requests_sent  = 0;
        cycle_count    = 0;
        cur_eps        = EPS_RESET;
        box_h          = 4 * ONE;
        tracker        = new();

        eps_set  = '{16'd0, 16'hFFFF, 16'($urandom_range(65535)), 16'd1, 16'd1000};
        src_set  = '{0, 45, 0, 15, 0};
        sink_set = '{0, 0, 45, 15, 0};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset epsilon, no idling.
        // Fill the whole plane table before the first vertex test.
        h = 4 * ONE;
        load_box(h);
        send_vertex(0, 0, 0, 1'b1);                         // point at the center: inside
        send_vertex(-h - 655 - 1, 0, 0, 1'b1);              // one past the tolerance: culled
        send_vertex(-h - 655, 0, 0, 1'b1);                  // exactly at the tolerance: inside
        send_vertex(0, h + 655 + 1, 0, 1'b1);               // behind the -y plane
        send_vertex(-10 * ONE, 0, 0, 1'b0);                 // segment across the box: inside
        send_vertex(10 * ONE, 0, 0, 1'b1);
        send_vertex(-ONE, 2 * ONE, 20 * ONE, 1'b0);         // all beyond +z: culled
        send_vertex(ONE, -3 * ONE, 21 * ONE, 1'b0);
        send_vertex(0, 0, 30 * ONE, 1'b1);
        // coefficient written in the middle of a shape applies to later vertices
        send_vertex(20 * ONE, 0, 0, 1'b0);
        send_write(1, COEF_D, 100 * ONE);
        send_vertex(20 * ONE, 0, 0, 1'b1);
        send_write(1, COEF_D, h);
        // writes to plane indexes past the table are dropped
        send_write(6, COEF_D, 32'h8000_0000);
        send_write(7, COEF_NX, 32'h8000_0000);
        send_vertex(0, 0, 0, 1'b1);
        // extreme vertex coordinates
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        // most negative normal against the most negative coordinate
        send_write(0, COEF_NX, 32'h8000_0000);
        send_vertex(32'h8000_0000, 0, 0, 1'b1);
        send_write(0, COEF_NX, ONE);
        bus_idle();
        drain();

        // Random phases, each at its own epsilon and idling pattern
        for (int ph = 0; ph < 5; ph++) begin
            write_epsilon(eps_set[ph]);
            src_idle_pct   = src_set[ph];
            sink_stall_pct = sink_set[ph];
            // first phase: hold the receiver off while requests keep coming
            if (ph == 0)
                hold_req++;
            run_phase(PHASE_ITEMS);
            bus_idle();
            drain();
        end

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("** frustum_box_cull_test: PASSED **");
        end else begin
            $display("** frustum_box_cull_test: FAILED **");
        end
        $finish;
    end

endmodule
